/* hdl/mme_pkg.sv */
// ----------------------------------------------------------------------------
// Matrix multiply engine package
// Shared sizes, register indexes, types and helper functions.
// ----------------------------------------------------------------------------
package mme_pkg;

   localparam int MAX_DIM         = 8;
   localparam int ELEM_WIDTH      = 16;
   localparam int VALUE_WIDTH     = 35;
   localparam int IDX_WIDTH       = 3;
   localparam int CFG_WIDTH       = 4;
   localparam int CSR_INDEX_WIDTH = 2;

   localparam logic [CSR_INDEX_WIDTH-1:0] REG_ROWS_A     = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_INNER_SIZE = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_COLS_B     = 2'd2;

   localparam logic [CFG_WIDTH-1:0] RESET_ROWS_A     = 4'd2;
   localparam logic [CFG_WIDTH-1:0] RESET_INNER_SIZE = 4'd3;
   localparam logic [CFG_WIDTH-1:0] RESET_COLS_B     = 4'd2;

   localparam int STORE_DEPTH = MAX_DIM * MAX_DIM;
   localparam int ADDR_WIDTH  = $clog2(STORE_DEPTH);
   localparam int CNT_WIDTH   = ADDR_WIDTH + 1;
   localparam int DIM_BITS    = $clog2(MAX_DIM);
   localparam int SIZE_WIDTH  = $clog2(MAX_DIM + 1);
   localparam int PROD_WIDTH  = 2 * ELEM_WIDTH;
   localparam int WIDE_WIDTH  = 64;

   localparam int RSP_DEPTH     = 4;
   localparam int RSP_PTR_WIDTH = $clog2(RSP_DEPTH);
   localparam int RSP_CNT_WIDTH = $clog2(RSP_DEPTH + 1);

   typedef logic [SIZE_WIDTH-1:0] size_type;

   typedef struct packed {
      size_type m;
      size_type n;
      size_type p;
   } job_type;

   typedef struct packed {
      logic                  a_we;
      logic                  b_we;
      logic [ADDR_WIDTH-1:0] addr;
      logic [ELEM_WIDTH-1:0] data;
   } wr_type;

   typedef struct packed {
      logic                first;
      logic                lastk;
      logic                last;
      logic [DIM_BITS-1:0] row;
      logic [DIM_BITS-1:0] col;
   } tag_type;

   typedef struct packed {
      logic [VALUE_WIDTH-1:0] value;
      logic [IDX_WIDTH-1:0]   row;
      logic [IDX_WIDTH-1:0]   col;
      logic                   last;
   } rsp_type;

   // A size of zero acts as one, and a size above the maximum acts as the maximum.
   function automatic size_type eff_size(input logic [CFG_WIDTH-1:0] v);
      size_type r;
      if (v == '0) begin
         r = size_type'(1);
      end else if (int'(v) > MAX_DIM) begin
         r = size_type'(MAX_DIM);
      end else begin
         r = size_type'(v);
      end
      return r;
   endfunction

endpackage

/* hdl/matrix_multiply_engine.sv */
// ----------------------------------------------------------------------------
// Matrix multiply engine
// Loads signed matrices A and B element by element and returns A times B
// in row-major order, one result element per request on the result queue.
// ----------------------------------------------------------------------------
//   Channel   Handshake              Payload
//   req       req_push / req_full    element
//   rsp       rsp_pop / rsp_empty    product_value, row, col, last
//   csr       csr_valid / csr_ready  index, data (rows_a, inner_size, cols_b)
//
// Once the back end takes the job queued by the last element of B, the single
// multiply-accumulate unit issues rows_a * cols_b * inner_size products, one a
// cycle; each result passes the store read register and the product register
// into the result queue. req_full is high from the cycle after the last
// element of B until the final product issues, and issue pauses while the
// four-entry result queue, counting results in flight, is full. Reset is
// synchronous and needs no clearing pass.
// ----------------------------------------------------------------------------
module matrix_multiply_engine (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_push,
   output logic                                req_full,
   input  logic signed [mme_pkg::ELEM_WIDTH-1:0] req_element,
   output logic                                rsp_empty,
   input  logic                                rsp_pop,
   output logic signed [mme_pkg::VALUE_WIDTH-1:0] rsp_product_value,
   output logic [mme_pkg::IDX_WIDTH-1:0]       rsp_row,
   output logic [mme_pkg::IDX_WIDTH-1:0]       rsp_col,
   output logic                                rsp_last,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [mme_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [mme_pkg::CFG_WIDTH-1:0]       csr_data
);

   logic                                job_push;
   logic                                job_pop;
   logic                                job_pending;
   logic                                back_busy;
   mme_pkg::job_type                    front_job;
   mme_pkg::job_type                    head_job;
   mme_pkg::wr_type                     wr;
   logic [mme_pkg::ADDR_WIDTH-1:0]      a_raddr, b_raddr;
   logic [mme_pkg::ELEM_WIDTH-1:0]      a_rdata, b_rdata;
   logic [mme_pkg::VALUE_WIDTH-1:0]     product_value;

   mme_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_full    (req_full),
      .req_element (req_element),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .job_pending (job_pending),
      .back_busy   (back_busy),
      .job_push    (job_push),
      .job         (front_job),
      .wr          (wr)
   );

   mme_job_queue u_job_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (job_push),
      .push_job (front_job),
      .pop      (job_pop),
      .pending  (job_pending),
      .head_job (head_job)
   );

   mme_ram #(
      .DEPTH (mme_pkg::STORE_DEPTH),
      .WIDTH (mme_pkg::ELEM_WIDTH)
   ) u_store_a (
      .clock (clock),
      .we    (wr.a_we),
      .waddr (wr.addr),
      .wdata (wr.data),
      .raddr (a_raddr),
      .rdata (a_rdata)
   );

   mme_ram #(
      .DEPTH (mme_pkg::STORE_DEPTH),
      .WIDTH (mme_pkg::ELEM_WIDTH)
   ) u_store_b (
      .clock (clock),
      .we    (wr.b_we),
      .waddr (wr.addr),
      .wdata (wr.data),
      .raddr (b_raddr),
      .rdata (b_rdata)
   );

   mme_back u_back (
      .clock             (clock),
      .reset             (reset),
      .job_pending       (job_pending),
      .job               (head_job),
      .job_pop           (job_pop),
      .busy              (back_busy),
      .a_raddr           (a_raddr),
      .b_raddr           (b_raddr),
      .a_rdata           (a_rdata),
      .b_rdata           (b_rdata),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_product_value (product_value),
      .rsp_row           (rsp_row),
      .rsp_col           (rsp_col),
      .rsp_last          (rsp_last)
   );

   assign rsp_product_value = product_value;

endmodule

/* hdl/mme_ram.sv */
// ----------------------------------------------------------------------------
// Matrix multiply engine element store
// Simple dual-port memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
module mme_ram #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         store_ff[waddr] <= wdata;
      end
      rdata_ff <= store_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

/* hdl/mme_front.sv */
// ----------------------------------------------------------------------------
// Matrix multiply engine front end
// Holds the size registers, loads A and B into the stores and issues a job
// when the last element of B has arrived.
// ----------------------------------------------------------------------------
module mme_front (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_push,
   output logic                                  req_full,
   input  logic [mme_pkg::ELEM_WIDTH-1:0]        req_element,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [mme_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [mme_pkg::CFG_WIDTH-1:0]         csr_data,
   input  logic                                  job_pending,
   input  logic                                  back_busy,
   output logic                                  job_push,
   output mme_pkg::job_type                      job,
   output mme_pkg::wr_type                       wr
);

   localparam logic PHASE_A = 1'b0;
   localparam logic PHASE_B = 1'b1;

   logic [mme_pkg::CFG_WIDTH-1:0] rows_ff, rows_in;
   logic [mme_pkg::CFG_WIDTH-1:0] inner_ff, inner_in;
   logic [mme_pkg::CFG_WIDTH-1:0] cols_ff, cols_in;
   logic [mme_pkg::CNT_WIDTH-1:0] count_ff, count_in;
   logic                          phase_ff, phase_in;

   mme_pkg::size_type             m, n, p;
   logic [mme_pkg::CNT_WIDTH-1:0] total;
   logic [mme_pkg::CNT_WIDTH-1:0] count_inc;
   logic                          accept;
   logic                          done;
   logic                          known;

   assign m = mme_pkg::eff_size(rows_ff);
   assign n = mme_pkg::eff_size(inner_ff);
   assign p = mme_pkg::eff_size(cols_ff);

   assign req_full  = job_pending | back_busy;
   assign csr_ready = 1'b1;
   assign accept    = req_push & ~req_full;

   assign total     = (phase_ff == PHASE_A)
                    ? mme_pkg::CNT_WIDTH'(m) * mme_pkg::CNT_WIDTH'(n)
                    : mme_pkg::CNT_WIDTH'(n) * mme_pkg::CNT_WIDTH'(p);
   assign count_inc = count_ff + mme_pkg::CNT_WIDTH'(1);
   assign done      = (count_inc == total);

   assign wr.a_we = accept & (phase_ff == PHASE_A);
   assign wr.b_we = accept & (phase_ff == PHASE_B);
   assign wr.addr = count_ff[mme_pkg::ADDR_WIDTH-1:0];
   assign wr.data = req_element;

   assign job_push = accept & (phase_ff == PHASE_B) & done;
   assign job.m    = m;
   assign job.n    = n;
   assign job.p    = p;

   always_comb begin
      rows_in  = rows_ff;
      inner_in = inner_ff;
      cols_in  = cols_ff;
      count_in = count_ff;
      phase_in = phase_ff;
      known    = 1'b0;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            mme_pkg::REG_ROWS_A: begin
               rows_in = csr_data;
               known   = 1'b1;
            end
            mme_pkg::REG_INNER_SIZE: begin
               inner_in = csr_data;
               known    = 1'b1;
            end
            mme_pkg::REG_COLS_B: begin
               cols_in = csr_data;
               known   = 1'b1;
            end
            default: begin
               known = 1'b0;
            end
         endcase
      end
      if (known) begin
         count_in = '0;
         phase_in = PHASE_A;
      end else if (accept) begin
         if (done) begin
            count_in = '0;
            phase_in = ~phase_ff;
         end else begin
            count_in = count_inc;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff  <= mme_pkg::RESET_ROWS_A;
         inner_ff <= mme_pkg::RESET_INNER_SIZE;
         cols_ff  <= mme_pkg::RESET_COLS_B;
         count_ff <= '0;
         phase_ff <= PHASE_A;
      end else begin
         rows_ff  <= rows_in;
         inner_ff <= inner_in;
         cols_ff  <= cols_in;
         count_ff <= count_in;
         phase_ff <= phase_in;
      end
   end

endmodule

/* hdl/mme_job_queue.sv */
// ----------------------------------------------------------------------------
// Matrix multiply engine job queue
// Two-entry queue of matrix sizes between the front end and the back end.
// ----------------------------------------------------------------------------
module mme_job_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  mme_pkg::job_type push_job,
   input  logic             pop,
   output logic             pending,
   output mme_pkg::job_type head_job
);

   mme_pkg::job_type entry_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign pending  = (count_ff != 2'd0);
   assign head_job = entry_ff[rd_ptr_ff];
   assign do_push  = push & (count_ff != 2'd2);
   assign do_pop   = pop & pending;

   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

/* hdl/mme_back.sv */
// ----------------------------------------------------------------------------
// Matrix multiply engine back end
// Walks row, column and inner index with one multiply-accumulate unit and
// queues the finished result elements.
// ----------------------------------------------------------------------------
module mme_back (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  job_pending,
   input  mme_pkg::job_type                      job,
   output logic                                  job_pop,
   output logic                                  busy,
   output logic [mme_pkg::ADDR_WIDTH-1:0]        a_raddr,
   output logic [mme_pkg::ADDR_WIDTH-1:0]        b_raddr,
   input  logic signed [mme_pkg::ELEM_WIDTH-1:0] a_rdata,
   input  logic signed [mme_pkg::ELEM_WIDTH-1:0] b_rdata,
   output logic                                  rsp_empty,
   input  logic                                  rsp_pop,
   output logic [mme_pkg::VALUE_WIDTH-1:0]       rsp_product_value,
   output logic [mme_pkg::IDX_WIDTH-1:0]         rsp_row,
   output logic [mme_pkg::IDX_WIDTH-1:0]         rsp_col,
   output logic                                  rsp_last
);

   logic                           busy_ff, busy_in;
   mme_pkg::job_type               dims_ff, dims_in;
   logic [mme_pkg::DIM_BITS-1:0]   i_ff, i_in;
   logic [mme_pkg::DIM_BITS-1:0]   j_ff, j_in;
   logic [mme_pkg::DIM_BITS-1:0]   k_ff, k_in;
   logic [mme_pkg::ADDR_WIDTH-1:0] a_row_ff, a_row_in;
   logic [mme_pkg::ADDR_WIDTH-1:0] a_addr_ff, a_addr_in;
   logic [mme_pkg::ADDR_WIDTH-1:0] b_addr_ff, b_addr_in;

   logic                           v1_ff, v2_ff;
   mme_pkg::tag_type               t1_ff, t2_ff, t0;
   logic signed [mme_pkg::PROD_WIDTH-1:0] prod_ff;
   logic [mme_pkg::VALUE_WIDTH-1:0] acc_ff;
   logic signed [mme_pkg::WIDE_WIDTH-1:0] prod_wide;
   logic [mme_pkg::VALUE_WIDTH-1:0] acc_sum;

   mme_pkg::rsp_type                  rsp_ff [mme_pkg::RSP_DEPTH];
   logic [mme_pkg::RSP_PTR_WIDTH-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [mme_pkg::RSP_CNT_WIDTH-1:0] cnt_ff, cnt_in;
   logic [mme_pkg::RSP_CNT_WIDTH-1:0] inflight;
   mme_pkg::rsp_type                  rsp_new;
   mme_pkg::rsp_type                  rsp_head;

   logic room, issue, k_last, j_last, i_last, push, pop;

   assign inflight = mme_pkg::RSP_CNT_WIDTH'(v1_ff & t1_ff.lastk)
                   + mme_pkg::RSP_CNT_WIDTH'(v2_ff & t2_ff.lastk);
   assign room     = (cnt_ff + inflight) < mme_pkg::RSP_CNT_WIDTH'(mme_pkg::RSP_DEPTH);
   assign issue    = busy_ff & room;
   assign job_pop  = ~busy_ff & job_pending;
   assign busy     = busy_ff;
   assign a_raddr  = a_addr_ff;
   assign b_raddr  = b_addr_ff;

   assign k_last = (mme_pkg::SIZE_WIDTH'(k_ff) == dims_ff.n - mme_pkg::SIZE_WIDTH'(1));
   assign j_last = (mme_pkg::SIZE_WIDTH'(j_ff) == dims_ff.p - mme_pkg::SIZE_WIDTH'(1));
   assign i_last = (mme_pkg::SIZE_WIDTH'(i_ff) == dims_ff.m - mme_pkg::SIZE_WIDTH'(1));

   assign t0.first = (k_ff == '0);
   assign t0.lastk = k_last;
   assign t0.last  = i_last & j_last & k_last;
   assign t0.row   = i_ff;
   assign t0.col   = j_ff;

   always_comb begin
      busy_in   = busy_ff;
      dims_in   = dims_ff;
      i_in      = i_ff;
      j_in      = j_ff;
      k_in      = k_ff;
      a_row_in  = a_row_ff;
      a_addr_in = a_addr_ff;
      b_addr_in = b_addr_ff;
      if (job_pop) begin
         busy_in   = 1'b1;
         dims_in   = job;
         i_in      = '0;
         j_in      = '0;
         k_in      = '0;
         a_row_in  = '0;
         a_addr_in = '0;
         b_addr_in = '0;
      end else if (issue) begin
         if (!k_last) begin
            k_in      = k_ff + mme_pkg::DIM_BITS'(1);
            a_addr_in = a_addr_ff + mme_pkg::ADDR_WIDTH'(1);
            b_addr_in = b_addr_ff + mme_pkg::ADDR_WIDTH'(dims_ff.p);
         end else if (!j_last) begin
            k_in      = '0;
            j_in      = j_ff + mme_pkg::DIM_BITS'(1);
            a_addr_in = a_row_ff;
            b_addr_in = mme_pkg::ADDR_WIDTH'(j_ff) + mme_pkg::ADDR_WIDTH'(1);
         end else if (!i_last) begin
            k_in      = '0;
            j_in      = '0;
            i_in      = i_ff + mme_pkg::DIM_BITS'(1);
            a_row_in  = a_row_ff + mme_pkg::ADDR_WIDTH'(dims_ff.n);
            a_addr_in = a_row_ff + mme_pkg::ADDR_WIDTH'(dims_ff.n);
            b_addr_in = '0;
         end else begin
            busy_in = 1'b0;
         end
      end
   end

   assign prod_wide = mme_pkg::WIDE_WIDTH'(prod_ff);
   assign acc_sum   = (t2_ff.first ? '0 : acc_ff) + prod_wide[mme_pkg::VALUE_WIDTH-1:0];

   assign push          = v2_ff & t2_ff.lastk;
   assign pop           = rsp_pop & ~rsp_empty;
   assign rsp_new.value = acc_sum;
   assign rsp_new.row   = mme_pkg::IDX_WIDTH'(t2_ff.row);
   assign rsp_new.col   = mme_pkg::IDX_WIDTH'(t2_ff.col);
   assign rsp_new.last  = t2_ff.last;

   always_comb begin
      cnt_in = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + mme_pkg::RSP_CNT_WIDTH'(1);
      end else if (pop && !push) begin
         cnt_in = cnt_ff - mme_pkg::RSP_CNT_WIDTH'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff   <= 1'b0;
         v1_ff     <= 1'b0;
         v2_ff     <= 1'b0;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         busy_ff <= busy_in;
         v1_ff   <= issue;
         v2_ff   <= v1_ff;
         cnt_ff  <= cnt_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + mme_pkg::RSP_PTR_WIDTH'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + mme_pkg::RSP_PTR_WIDTH'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      dims_ff   <= dims_in;
      i_ff      <= i_in;
      j_ff      <= j_in;
      k_ff      <= k_in;
      a_row_ff  <= a_row_in;
      a_addr_ff <= a_addr_in;
      b_addr_ff <= b_addr_in;
      t1_ff     <= t0;
      t2_ff     <= t1_ff;
      prod_ff   <= a_rdata * b_rdata;
      if (v2_ff) begin
         acc_ff <= acc_sum;
      end
      if (push) begin
         rsp_ff[wr_ptr_ff] <= rsp_new;
      end
   end

   assign rsp_head          = rsp_ff[rd_ptr_ff];
   assign rsp_empty         = (cnt_ff == '0);
   assign rsp_product_value = rsp_head.value;
   assign rsp_row           = rsp_head.row;
   assign rsp_col           = rsp_head.col;
   assign rsp_last          = rsp_head.last;

endmodule

/* hdl/mme_checker.sv */
// ----------------------------------------------------------------------------
// Matrix multiply engine port checker
// Watches the top-level ports for reset behavior and result queue rules.
// ----------------------------------------------------------------------------
module mme_checker (
   input logic                                   clock,
   input logic                                   reset,
   input logic                                   req_push,
   input logic                                   req_full,
   input logic [mme_pkg::ELEM_WIDTH-1:0]         req_element,
   input logic                                   rsp_empty,
   input logic                                   rsp_pop,
   input logic [mme_pkg::VALUE_WIDTH-1:0]        rsp_product_value,
   input logic [mme_pkg::IDX_WIDTH-1:0]          rsp_row,
   input logic [mme_pkg::IDX_WIDTH-1:0]          rsp_col,
   input logic                                   rsp_last,
   input logic                                   csr_valid,
   input logic                                   csr_ready,
   input logic [mme_pkg::CSR_INDEX_WIDTH-1:0]    csr_index,
   input logic [mme_pkg::CFG_WIDTH-1:0]          csr_data
);

   // After reset the engine is ready for requests and holds no results.
   assert property (@(posedge clock) reset |=> (!req_full && rsp_empty))
      else $error("engine not idle after reset");

   // Register writes are never held off.
   assert property (@(posedge clock) disable iff (reset) csr_ready)
      else $error("configuration port not ready");

   // A waiting result is not withdrawn.
   assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> !rsp_empty)
      else $error("waiting result dropped");

   // A waiting result keeps its payload.
   assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> ($stable(rsp_product_value) && $stable(rsp_row)
                                    && $stable(rsp_col) && $stable(rsp_last)))
      else $error("waiting result changed");

endmodule

bind matrix_multiply_engine mme_checker u_mme_checker (.*);

/* tb/matrix_multiply_engine_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Matrix multiply engine checker
// Watches the request, result and register channels of the engine. It keeps
// its own copy of the size registers and of both matrix stores, predicts
// every product element when the last element of B is accepted, and compares
// each accepted result with the oldest prediction.
// ----------------------------------------------------------------------------
module matrix_multiply_engine_checker (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_push,
   input  logic                                   req_full,
   input  logic signed [mme_pkg::ELEM_WIDTH-1:0]  req_element,
   input  logic                                   rsp_empty,
   input  logic                                   rsp_pop,
   input  logic signed [mme_pkg::VALUE_WIDTH-1:0] rsp_product_value,
   input  logic [mme_pkg::IDX_WIDTH-1:0]          rsp_row,
   input  logic [mme_pkg::IDX_WIDTH-1:0]          rsp_col,
   input  logic                                   rsp_last,
   input  logic                                   csr_valid,
   input  logic                                   csr_ready,
   input  logic [mme_pkg::CSR_INDEX_WIDTH-1:0]    csr_index,
   input  logic [mme_pkg::CFG_WIDTH-1:0]          csr_data,
   output int                                     pending_results,
   output int                                     error_count
);

   localparam int MAX_REPORTS = 10;

   logic [mme_pkg::CFG_WIDTH-1:0]         rows_cfg;
   logic [mme_pkg::CFG_WIDTH-1:0]         inner_cfg;
   logic [mme_pkg::CFG_WIDTH-1:0]         cols_cfg;
   logic signed [mme_pkg::ELEM_WIDTH-1:0] a_store [mme_pkg::STORE_DEPTH];
   logic signed [mme_pkg::ELEM_WIDTH-1:0] b_store [mme_pkg::STORE_DEPTH];
   int                                    load_count;
   bit                                    loading_b;
   mme_pkg::rsp_type                      expected_products [$];
   mme_pkg::rsp_type                      want;
   int                                    failures;
   int                                    m, n, p;
   bit                                    known_reg;

   function automatic int active_dim(input logic [mme_pkg::CFG_WIDTH-1:0] v);
      if (v == '0) begin
         return 1;
      end
      if (int'(v) > mme_pkg::MAX_DIM) begin
         return mme_pkg::MAX_DIM;
      end
      return int'(v);
   endfunction

   function automatic void predict_products(input int rows, input int inner, input int cols);
      longint           acc;
      mme_pkg::rsp_type item;
      for (int i = 0; i < rows; i++) begin
         for (int j = 0; j < cols; j++) begin
            acc = 0;
            for (int k = 0; k < inner; k++) begin
               acc += longint'(a_store[i * inner + k]) * longint'(b_store[k * cols + j]);
            end
            item.value = acc[mme_pkg::VALUE_WIDTH-1:0];
            item.row   = mme_pkg::IDX_WIDTH'(i);
            item.col   = mme_pkg::IDX_WIDTH'(j);
            item.last  = (i == rows - 1) && (j == cols - 1);
            expected_products.push_back(item);
         end
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         rows_cfg   = mme_pkg::RESET_ROWS_A;
         inner_cfg  = mme_pkg::RESET_INNER_SIZE;
         cols_cfg   = mme_pkg::RESET_COLS_B;
         load_count = 0;
         loading_b  = 1'b0;
         failures   = 0;
         expected_products.delete();
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (expected_products.size() == 0) begin
               failures++;
               if (failures <= MAX_REPORTS) begin
                  $display("Unexpected result: value %0d row %0d col %0d last %0b",
                           rsp_product_value, rsp_row, rsp_col, rsp_last);
               end
            end else begin
               want = expected_products.pop_front();
               if (want.value !== rsp_product_value || want.row !== rsp_row ||
                   want.col !== rsp_col || want.last !== rsp_last) begin
                  failures++;
                  if (failures <= MAX_REPORTS) begin
                     $display({"Mismatch: expected value %0d row %0d col %0d last %0b,",
                               " got value %0d row %0d col %0d last %0b"},
                              $signed(want.value), want.row, want.col, want.last,
                              rsp_product_value, rsp_row, rsp_col, rsp_last);
                  end
               end
            end
         end

         if (csr_valid && csr_ready) begin
            known_reg = 1'b1;
            case (csr_index)
               mme_pkg::REG_ROWS_A: begin
                  rows_cfg = csr_data;
               end
               mme_pkg::REG_INNER_SIZE: begin
                  inner_cfg = csr_data;
               end
               mme_pkg::REG_COLS_B: begin
                  cols_cfg = csr_data;
               end
               default: begin
                  known_reg = 1'b0;
               end
            endcase
            if (known_reg) begin
               load_count = 0;
               loading_b  = 1'b0;
            end
         end

         if (req_push && !req_full) begin
            m = active_dim(rows_cfg);
            n = active_dim(inner_cfg);
            p = active_dim(cols_cfg);
            if (!loading_b) begin
               a_store[load_count] = req_element;
               load_count++;
               if (load_count >= m * n) begin
                  load_count = 0;
                  loading_b  = 1'b1;
               end
            end else begin
               b_store[load_count] = req_element;
               load_count++;
               if (load_count >= n * p) begin
                  load_count = 0;
                  loading_b  = 1'b0;
                  predict_products(m, n, p);
               end
            end
         end
      end
      pending_results <= expected_products.size();
      error_count     <= failures;
   end

endmodule

/* tb/matrix_multiply_engine_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Matrix multiply engine testbench
// Drives matrix elements and size register writes into the engine and pops
// its results with random gaps on both sides. A directed set covers the
// element extremes, size clamping and load restarts; later phases then run two
// fixed-size cases and many matrix pairs of random sizes and content. The
// checker beside the engine predicts and compares every result.
// ----------------------------------------------------------------------------
module matrix_multiply_engine_tb;

   typedef logic signed [mme_pkg::ELEM_WIDTH-1:0] element_type;
   typedef logic [mme_pkg::CFG_WIDTH-1:0]         cfg_value_type;

   localparam logic [mme_pkg::CSR_INDEX_WIDTH-1:0] REG_UNUSED = 2'd3;
   localparam element_type ELEM_MIN     = {1'b1, {(mme_pkg::ELEM_WIDTH-1){1'b0}}};
   localparam element_type ELEM_MAX     = ~ELEM_MIN;
   localparam int       ITEM_TARGET     = 170;
   localparam int       IDLE_LIMIT      = 2000;
   localparam int       RSP_HOLD_CYCLES = 400;
   localparam int       SETTLE_CYCLES   = 8;
   localparam int       DRAIN_CYCLES    = 20;

   logic                                   clock;
   logic                                   reset;
   logic                                   req_push;
   logic                                   req_full;
   element_type                            req_element;
   logic                                   rsp_empty;
   logic                                   rsp_pop;
   logic signed [mme_pkg::VALUE_WIDTH-1:0] rsp_product_value;
   logic [mme_pkg::IDX_WIDTH-1:0]          rsp_row;
   logic [mme_pkg::IDX_WIDTH-1:0]          rsp_col;
   logic                                   rsp_last;
   logic                                   csr_valid;
   logic                                   csr_ready;
   logic [mme_pkg::CSR_INDEX_WIDTH-1:0]    csr_index;
   cfg_value_type                          csr_data;

   int pending_results;
   int error_count;
   int items_sent;
   int idle_cycles;
   bit req_burst;
   bit rsp_burst;
   int rsp_gap;
   int next_gap;
   bit hold_trigger;
   bit hold_done;
   int hold_left;

   matrix_multiply_engine uut (
      .clock             (clock),
      .reset             (reset),
      .req_push          (req_push),
      .req_full          (req_full),
      .req_element       (req_element),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_product_value (rsp_product_value),
      .rsp_row           (rsp_row),
      .rsp_col           (rsp_col),
      .rsp_last          (rsp_last),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   matrix_multiply_engine_checker product_checker (
      .clock             (clock),
      .reset             (reset),
      .req_push          (req_push),
      .req_full          (req_full),
      .req_element       (req_element),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_product_value (rsp_product_value),
      .rsp_row           (rsp_row),
      .rsp_col           (rsp_col),
      .rsp_last          (rsp_last),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .pending_results   (pending_results),
      .error_count       (error_count)
   );

   initial begin
      clock = 1'b0;
   end

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // The result side pops with random gaps and one long hold-off on request.
   always @(posedge clock) begin
      if (reset) begin
         rsp_pop   <= 1'b0;
         rsp_gap   <= 0;
         rsp_burst <= 1'b0;
         hold_done <= 1'b0;
         hold_left <= 0;
      end else if (hold_trigger && !hold_done) begin
         rsp_pop   <= 1'b0;
         hold_done <= 1'b1;
         hold_left <= RSP_HOLD_CYCLES;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
      end else if (rsp_pop && !rsp_empty) begin
         next_gap = rsp_burst ? 0 : $urandom_range(19, 0);
         if ($urandom_range(15, 0) == 0) begin
            rsp_burst <= !rsp_burst;
         end
         if (next_gap > 0) begin
            rsp_pop <= 1'b0;
            rsp_gap <= next_gap - 1;
         end
      end else if (!rsp_pop) begin
         if (rsp_gap > 0) begin
            rsp_gap <= rsp_gap - 1;
         end else begin
            rsp_pop <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic element_type draw_element(input bit extreme);
      if (extreme || $urandom_range(7, 0) == 0) begin
         return $urandom_range(1, 0) ? ELEM_MAX : ELEM_MIN;
      end
      return element_type'($urandom);
   endfunction

   function automatic int draw_dim();
      int r;
      r = $urandom_range(9, 0);
      if (r < 6) begin
         return $urandom_range(3, 1);
      end else if (r < 8) begin
         return $urandom_range(7, 4);
      end
      return mme_pkg::MAX_DIM;
   endfunction

   // Sizes of one and of the maximum are often written as zero or as an
   // out-of-range value, which the engine clamps.
   function automatic cfg_value_type encode_size(input int dim);
      if (dim == 1 && $urandom_range(1, 0) == 1) begin
         return '0;
      end else if (dim == mme_pkg::MAX_DIM) begin
         return cfg_value_type'($urandom_range(15, mme_pkg::MAX_DIM));
      end
      return cfg_value_type'(dim);
   endfunction

   task automatic push_element(input element_type value);
      int gap;
      gap = req_burst ? 0 : $urandom_range(19, 0);
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_push    <= 1'b1;
      req_element <= value;
      do @(posedge clock); while (req_full);
      items_sent++;
   endtask

   task automatic wait_for_idle();
      req_push <= 1'b0;
      do @(posedge clock); while (pending_results != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [mme_pkg::CSR_INDEX_WIDTH-1:0] index,
                                 input cfg_value_type value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
   endtask

   initial begin
      element_type default_set [12];
      int          phase;
      int          rows;
      int          inner;
      int          cols;
      int          matrices;
      int          pair_items;
      bit          extreme;

      default_set = '{ELEM_MAX, ELEM_MIN, 0, -1, 1, ELEM_MAX,
                      ELEM_MIN, ELEM_MAX, ELEM_MIN, 1, 0, -1};
      reset        = 1'b1;
      req_push     = 1'b0;
      req_element  = '0;
      csr_valid    = 1'b0;
      csr_index    = mme_pkg::REG_ROWS_A;
      csr_data     = '0;
      hold_trigger = 1'b0;
      req_burst    = 1'b0;
      items_sent   = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (default_set[i]) begin
         push_element(default_set[i]);
      end

      wait_for_idle();
      write_register(mme_pkg::REG_ROWS_A, '0);
      write_register(mme_pkg::REG_INNER_SIZE, cfg_value_type'(1));
      write_register(mme_pkg::REG_COLS_B, cfg_value_type'(1));
      csr_valid <= 1'b0;
      push_element(ELEM_MIN);
      push_element(ELEM_MIN);

      // A write to an unknown register keeps the partial load, while a write
      // to a size register discards it.
      wait_for_idle();
      write_register(mme_pkg::REG_ROWS_A, cfg_value_type'(1));
      write_register(mme_pkg::REG_INNER_SIZE, cfg_value_type'(2));
      write_register(mme_pkg::REG_COLS_B, cfg_value_type'(1));
      csr_valid <= 1'b0;
      push_element(draw_element(1'b0));
      wait_for_idle();
      write_register(REG_UNUSED, cfg_value_type'($urandom));
      csr_valid <= 1'b0;
      repeat (3) push_element(draw_element(1'b0));
      push_element(draw_element(1'b0));
      wait_for_idle();
      write_register(mme_pkg::REG_ROWS_A, cfg_value_type'(1));
      csr_valid <= 1'b0;
      repeat (4) push_element(draw_element(1'b0));

      for (phase = 0; items_sent < ITEM_TARGET; phase++) begin
         wait_for_idle();
         if (phase == 0) begin
            rows     = 1;
            inner    = mme_pkg::MAX_DIM;
            cols     = 1;
            extreme  = 1'b1;
            matrices = 1;
            req_burst <= 1'b0;
         end else if (phase == 1) begin
            rows     = mme_pkg::MAX_DIM;
            inner    = 1;
            cols     = mme_pkg::MAX_DIM;
            extreme  = 1'b0;
            matrices = 2;
            req_burst <= 1'b1;
         end else begin
            rows     = draw_dim();
            inner    = draw_dim();
            cols     = draw_dim();
            extreme  = ($urandom_range(4, 0) == 0);
            matrices = $urandom_range(3, 1);
            req_burst <= ($urandom_range(3, 0) == 0);
         end
         if ($urandom_range(3, 0) == 0) begin
            write_register(REG_UNUSED, cfg_value_type'($urandom));
         end
         write_register(mme_pkg::REG_ROWS_A, encode_size(rows));
         write_register(mme_pkg::REG_INNER_SIZE, encode_size(inner));
         write_register(mme_pkg::REG_COLS_B, encode_size(cols));
         csr_valid <= 1'b0;
         if (phase == 1) begin
            hold_trigger <= 1'b1;
         end
         pair_items = rows * inner + inner * cols;
         repeat (matrices) begin
            repeat (pair_items) begin
               if (items_sent < ITEM_TARGET) begin
                  push_element(draw_element(extreme));
               end
            end
         end
         if (phase > 1 && $urandom_range(5, 0) == 0) begin
            repeat ($urandom_range(pair_items - 1, 1)) begin
               if (items_sent < ITEM_TARGET) begin
                  push_element(draw_element(extreme));
               end
            end
         end
      end

      wait_for_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
